>>> rtl/sfoiir_pkg.sv
// ----------------------------------------------------------------------------
// sfoiir_pkg
// Shared widths, payload structs and register codes for the stereo IIR filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfoiir_pkg;

    localparam int SAMPLE_WIDTH    = 24;
    localparam int COEF_WIDTH      = 32;
    localparam int COEF_FRAC_BITS  = 27;
    localparam int NUM_REGS        = 7;
    localparam int CFG_INDEX_WIDTH = $clog2(NUM_REGS);
    // seven products of COEF_WIDTH x SAMPLE_WIDTH bits or one bit wider, plus headroom
    localparam int ACC_WIDTH       = COEF_WIDTH + SAMPLE_WIDTH + 4;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [COEF_WIDTH-1:0]   coef_t;

    typedef struct packed {
        sample_t sample_left;
        sample_t sample_right;
    } sample_in_t;

    typedef struct packed {
        sample_t filtered_left;
        sample_t filtered_right;
    } sample_out_t;

    typedef struct packed {
        coef_t ff_tap_zero;
        coef_t ff_tap_one;
        coef_t ff_tap_two;
        coef_t fb_tap_one;
        coef_t fb_tap_two;
        coef_t fb_tap_three;
        coef_t fb_tap_four;
    } coef_set_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_FF_TAP_ZERO  = 0,
        REG_FF_TAP_ONE   = 1,
        REG_FF_TAP_TWO   = 2,
        REG_FB_TAP_ONE   = 3,
        REG_FB_TAP_TWO   = 4,
        REG_FB_TAP_THREE = 5,
        REG_FB_TAP_FOUR  = 6
    } cfg_reg_t;

endpackage

>>> rtl/sfoiir_cfg.sv
// ----------------------------------------------------------------------------
// sfoiir_cfg
// Coefficient register bank, written through the configuration port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfoiir_cfg (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [sfoiir_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [sfoiir_pkg::COEF_WIDTH-1:0]      cfg_data,
    output sfoiir_pkg::coef_set_t                  coefs
);

    sfoiir_pkg::coef_set_t coef_reg;
    sfoiir_pkg::coef_set_t coef_next;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_wr_en)
        begin
            unique case (sfoiir_pkg::cfg_reg_t'(cfg_index))
                sfoiir_pkg::REG_FF_TAP_ZERO:  coef_next.ff_tap_zero  = cfg_data;
                sfoiir_pkg::REG_FF_TAP_ONE:   coef_next.ff_tap_one   = cfg_data;
                sfoiir_pkg::REG_FF_TAP_TWO:   coef_next.ff_tap_two   = cfg_data;
                sfoiir_pkg::REG_FB_TAP_ONE:   coef_next.fb_tap_one   = cfg_data;
                sfoiir_pkg::REG_FB_TAP_TWO:   coef_next.fb_tap_two   = cfg_data;
                sfoiir_pkg::REG_FB_TAP_THREE: coef_next.fb_tap_three = cfg_data;
                sfoiir_pkg::REG_FB_TAP_FOUR:  coef_next.fb_tap_four  = cfg_data;
                default:                      coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coefs = coef_reg;

endmodule

>>> rtl/sfoiir_chan.sv
// ----------------------------------------------------------------------------
// sfoiir_chan
// One channel: direct-form-I fourth-order section with its history registers,
// round-half-up and saturation to the sample width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfoiir_chan (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sfoiir_pkg::coef_set_t coefs,
    input  sfoiir_pkg::sample_t   sample,
    input  logic                  advance,
    output sfoiir_pkg::sample_t   result
);

    localparam int SW    = sfoiir_pkg::SAMPLE_WIDTH;
    localparam int CW    = sfoiir_pkg::COEF_WIDTH;
    localparam int FB    = sfoiir_pkg::COEF_FRAC_BITS;
    localparam int ACC_W = sfoiir_pkg::ACC_WIDTH;
    localparam int SH_W  = ACC_W - FB;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FB - 1);
    localparam logic signed [SW-1:0]    SAT_MAX    = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0]    SAT_MIN    = {1'b1, {(SW-1){1'b0}}};

    sfoiir_pkg::sample_t x_hist_reg [4];
    sfoiir_pkg::sample_t y_hist_reg [4];

    logic signed [SW:0]         x_pair_outer;
    logic signed [SW:0]         x_pair_inner;
    logic signed [CW+SW:0]      p_ff_zero;
    logic signed [CW+SW:0]      p_ff_one;
    logic signed [CW+SW-1:0]    p_ff_two;
    logic signed [CW+SW-1:0]    p_fb [4];
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    acc_rnd;
    logic signed [SH_W-1:0]     shifted;
    logic                       hi_ones;
    logic                       hi_zeros;

    // symmetric feed-forward taps share one multiplier per pair
    assign x_pair_outer = (SW+1)'(sample) + (SW+1)'(x_hist_reg[3]);
    assign x_pair_inner = (SW+1)'(x_hist_reg[0]) + (SW+1)'(x_hist_reg[2]);

    assign p_ff_zero = coefs.ff_tap_zero * x_pair_outer;
    assign p_ff_one  = coefs.ff_tap_one * x_pair_inner;
    assign p_ff_two  = coefs.ff_tap_two * x_hist_reg[1];
    assign p_fb[0]   = coefs.fb_tap_one * y_hist_reg[0];
    assign p_fb[1]   = coefs.fb_tap_two * y_hist_reg[1];
    assign p_fb[2]   = coefs.fb_tap_three * y_hist_reg[2];
    assign p_fb[3]   = coefs.fb_tap_four * y_hist_reg[3];

    assign acc = ACC_W'(p_ff_zero) + ACC_W'(p_ff_one) + ACC_W'(p_ff_two)
               - ACC_W'(p_fb[0]) - ACC_W'(p_fb[1])
               - ACC_W'(p_fb[2]) - ACC_W'(p_fb[3]);

    assign acc_rnd  = acc + ROUND_HALF;
    assign shifted  = acc_rnd[ACC_W-1:FB];
    assign hi_ones  = &shifted[SH_W-1:SW-1];
    assign hi_zeros = ~|shifted[SH_W-1:SW-1];

    always_comb
    begin
        priority if (hi_ones || hi_zeros)
        begin
            result = shifted[SW-1:0];
        end
        else if (shifted[SH_W-1])
        begin
            result = SAT_MIN;
        end
        else
        begin
            result = SAT_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                x_hist_reg[i] <= '0;
                y_hist_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            for (int i = 3; i > 0; i--)
            begin
                x_hist_reg[i] <= x_hist_reg[i-1];
                y_hist_reg[i] <= y_hist_reg[i-1];
            end
            x_hist_reg[0] <= sample;
            y_hist_reg[0] <= result;
        end
    end

endmodule

>>> rtl/stereo_fourth_order_iir_filter.sv
// ----------------------------------------------------------------------------
// stereo_fourth_order_iir_filter
// An accepted request goes to the input register, then the result register.
// Throughput: one stereo request per cycle unless out_stall holds a result; the
// input register, per-channel filter datapath and result register set this.
// Reset clears coefficients, both histories and all valid flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stereo_fourth_order_iir_filter (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  sfoiir_pkg::sample_in_t                 in_data,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output sfoiir_pkg::sample_out_t                out_data,
    input  logic                                   cfg_wr_en,
    input  logic [sfoiir_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [sfoiir_pkg::COEF_WIDTH-1:0]      cfg_data
);

    sfoiir_pkg::coef_set_t   coefs;
    sfoiir_pkg::sample_in_t  in_reg;
    sfoiir_pkg::sample_out_t out_reg;
    sfoiir_pkg::sample_out_t out_next;
    logic                    in_vld_reg;
    logic                    out_vld_reg;
    logic                    advance;
    logic                    in_accept;

    assign advance   = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    sfoiir_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coefs     (coefs)
    );

    sfoiir_chan u_chan_left (
        .clk     (clk),
        .rst_n   (rst_n),
        .coefs   (coefs),
        .sample  (in_reg.sample_left),
        .advance (advance),
        .result  (out_next.filtered_left)
    );

    sfoiir_chan u_chan_right (
        .clk     (clk),
        .rst_n   (rst_n),
        .coefs   (coefs),
        .sample  (in_reg.sample_right),
        .advance (advance),
        .result  (out_next.filtered_right)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_vld_reg <= 1'b0;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_reg <= in_data;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_vld_reg)
        else $error("computed request did not reach the result register");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_vld_reg && out_vld_reg && out_stall))
        else $error("input stalled without a blocked result");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_vld_reg)
        else $error("accepted request lost from input register");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_stall && !advance) |=> !out_vld_reg)
        else $error("delivered result repeated");
`endif

endmodule
